### src/lkr_pkg.sv
// ----------------------------------------------------------------------------
// lkr_pkg: shared types and constants for the LRU-K frame replacer
// Operation and status codes, default size, config register selector.
// ----------------------------------------------------------------------------
package lkr_pkg;
	localparam int FRAMES_DEF = 64;

	typedef enum logic [1:0] {
		OP_ACCESS = 2'd0,
		OP_MARK   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_EVICT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_RANGE  = 2'd2,
		ST_PINNED = 2'd3
	} status_t;

	localparam logic [0:0] CFG_DEPTH  = 1'b0;
	localparam logic [0:0] CFG_FRAMES = 1'b1;
endpackage

### src/lru_k_frame_replacer.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer: LRU-K page frame replacement
// Per-frame state plus cold and hot order lists held in RAM.
// ----------------------------------------------------------------------------
// One request at a time. A sequencer walks a list RAM entry by entry, a read
// state then a compare state for each, through a single shared compare unit
// (find a frame, or find the first evictable entry), then closes the gap by
// copying each later entry down one place, reading it and then writing it.
// Access counts live in a small RAM and are read back in the state after an
// access to a present frame is taken. Out-of-range requests and evicts with
// nothing evictable go straight to the output register; mark requests and
// first accesses pass the tail-effects state first, a repeat access that stays
// cold also reads its count; remove, evict and a relinking access add the list
// scan and the shift-down on the list RAM port. The result sits in an output
// register, so the next request is taken once it is read.
module lru_k_frame_replacer
	#(
	parameter int FRAMES = lkr_pkg::FRAMES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [5:0] frame,
	input  logic       evictable_flag,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic       victim_valid,
	output logic [5:0] victim_frame,
	output logic [6:0] evictable_count,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [6:0] cfg_data
);
	import lkr_pkg::*;

	localparam int AW = $clog2(FRAMES);
	localparam int LW = $clog2(FRAMES + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_LOOK  = 8'b00000010, // access count read back
		S_SCAN  = 8'b00000100, // issue read of position pos_q
		S_CHECK = 8'b00001000, // compare read data
		S_SHIFT = 8'b00010000, // read pos+1
		S_MOVE  = 8'b00100000, // write pos
		S_FIN   = 8'b01000000, // apply tail effects
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q;

	// configuration
	logic [3:0] depth_q;
	logic [6:0] inuse_q;
	assign cfg_ready = (state_q == S_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 4'd2;
			inuse_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_DEPTH) depth_q <= cfg_data[3:0];
			else inuse_q <= cfg_data;
		end
	end
	logic [3:0] k;
	assign k = (depth_q == 4'd0) ? 4'd1 : depth_q;

	// per-frame flags (reset to zero)
	logic [FRAMES-1:0] pres_q, evic_q, hot_q;
	logic [LW-1:0]     clen_q, hlen_q, etot_q;

	// request registers
	op_t        op_q;
	logic [5:0] f_q;
	logic       flag_q;
	logic [3:0] cnt_q;   // access count of the addressed frame
	logic [AW-1:0] fa, fi;
	assign fa = AW'(f_q);
	assign fi = AW'(frame);

	// scan control
	logic          lst_q;   // 0 cold, 1 hot
	logic [LW-1:0] pos_q;
	logic          push_q;  // append f to hot after the shift
	logic          forget_q;

	// list RAMs
	logic          c_we, h_we;
	logic [AW-1:0] waddr, raddr;
	logic [5:0]    wdata, c_rd, h_rd, rd;
	lkr_ram #(.WIDTH(6), .DEPTH(FRAMES)) u_cold (
		.clk(clk), .we(c_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(c_rd));
	lkr_ram #(.WIDTH(6), .DEPTH(FRAMES)) u_hot (
		.clk(clk), .we(h_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(h_rd));
	assign rd = lst_q ? h_rd : c_rd;

	// access counts; an entry is only read while its frame is present,
	// and a frame's first access always writes it
	logic       cnt_we;
	logic [3:0] cnt_wd, cnt_rd;
	lkr_ram #(.WIDTH(4), .DEPTH(FRAMES)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(fa), .wdata(cnt_wd), .raddr(fi), .rdata(cnt_rd));

	logic [LW-1:0] len;
	assign len = lst_q ? hlen_q : clen_q;

	// shared compare unit: match target frame, or first evictable entry
	logic hit;
	assign hit = (op_q == OP_EVICT) ? evic_q[AW'(rd)] : (rd == f_q);

	logic [LW-1:0] pos_n;
	assign pos_n = pos_q + LW'(1);

	logic [1:0] st_q;
	logic       vv_q;
	logic [5:0] vf_q;

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = (state_q == S_OUT);
	assign status          = st_q;
	assign victim_valid    = vv_q;
	assign victim_frame    = vf_q;
	assign evictable_count = 7'(etot_q);

	// RAM port drive; FIN appends at a list tail (relinked or new frame)
	always_comb begin
		c_we   = 1'b0;
		h_we   = 1'b0;
		waddr  = pos_q[AW-1:0];
		wdata  = rd;
		raddr  = pos_q[AW-1:0];
		cnt_we = 1'b0;
		cnt_wd = (cnt_q < k) ? cnt_q + 4'd1 : cnt_q;
		if (state_q == S_SHIFT) raddr = pos_n[AW-1:0];
		if (state_q == S_MOVE) begin
			c_we = !lst_q;
			h_we = lst_q;
		end
		if (state_q == S_FIN) begin
			wdata = f_q;
			if (push_q) begin
				h_we  = 1'b1;
				waddr = hlen_q[AW-1:0];
			end else if (op_q == OP_ACCESS && !forget_q && !pres_q[fa]) begin
				if (k <= 4'd1) begin
					h_we  = 1'b1;
					waddr = hlen_q[AW-1:0];
				end else begin
					c_we  = 1'b1;
					waddr = clen_q[AW-1:0];
				end
			end
			if (op_q == OP_ACCESS && !forget_q) begin
				cnt_we = 1'b1;
				if (!pres_q[fa]) cnt_wd = 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pres_q   <= '0;
			evic_q   <= '0;
			hot_q    <= '0;
			clen_q   <= '0;
			hlen_q   <= '0;
			etot_q   <= '0;
			op_q     <= OP_ACCESS;
			f_q      <= '0;
			flag_q   <= 1'b0;
			cnt_q    <= 4'd0;
			lst_q    <= 1'b0;
			pos_q    <= '0;
			push_q   <= 1'b0;
			forget_q <= 1'b0;
			st_q     <= ST_OK;
			vv_q     <= 1'b0;
			vf_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					op_q     <= op_t'(operation);
					f_q      <= frame;
					flag_q   <= evictable_flag;
					st_q     <= ST_OK;
					vv_q     <= 1'b0;
					vf_q     <= '0;
					push_q   <= 1'b0;
					forget_q <= 1'b0;
					pos_q    <= '0;
					if (op_t'(operation) == OP_EVICT) begin
						lst_q   <= 1'b0;
						state_q <= S_SCAN;
						if (etot_q == '0) begin
							st_q    <= ST_EMPTY;
							state_q <= S_OUT;
						end
					end else if ({1'b0, frame} >= inuse_q || 32'(frame) >= FRAMES) begin
						st_q    <= ST_RANGE;
						state_q <= S_OUT;
					end else begin
						state_q <= S_FIN;
						lst_q   <= hot_q[fi];
						case (op_t'(operation))
							OP_ACCESS: if (pres_q[fi]) state_q <= S_LOOK;
							OP_REMOVE: if (pres_q[fi]) begin
								if (evic_q[fi]) begin
									forget_q <= 1'b1;
									state_q  <= S_SCAN;
								end else st_q <= ST_PINNED;
							end
							default: ;
						endcase
					end
				end
				S_LOOK: begin
					cnt_q <= cnt_rd;
					// hot: always relink to tail; cold: only on reaching k
					if (hot_q[fa] || ({1'b0, cnt_rd} + 5'd1 >= {1'b0, k})) begin
						push_q  <= 1'b1;
						state_q <= S_SCAN;
					end else state_q <= S_FIN;
				end
				S_SCAN: begin
					if (pos_q >= len) begin
						if (op_q == OP_EVICT && !lst_q) begin
							lst_q <= 1'b1;
							pos_q <= '0;
						end else if (op_q == OP_EVICT) begin
							st_q    <= ST_EMPTY;
							state_q <= S_OUT;
						end else state_q <= S_FIN;
					end else state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (hit) begin
						if (op_q == OP_EVICT) begin
							f_q      <= rd;
							vf_q     <= rd;
							vv_q     <= 1'b1;
							forget_q <= 1'b1;
						end
						state_q <= S_SHIFT;
					end else begin
						pos_q   <= pos_n;
						state_q <= S_SCAN;
					end
				end
				S_SHIFT: begin
					if (pos_n >= len) begin
						if (lst_q) hlen_q <= hlen_q - LW'(1);
						else clen_q <= clen_q - LW'(1);
						state_q <= S_FIN;
					end else state_q <= S_MOVE;
				end
				S_MOVE: begin
					pos_q   <= pos_n;
					state_q <= S_SHIFT;
				end
				S_FIN: begin
					state_q <= S_OUT;
					if (forget_q) begin
						pres_q[fa] <= 1'b0;
						evic_q[fa] <= 1'b0;
						hot_q[fa]  <= 1'b0;
						if (etot_q != '0) etot_q <= etot_q - LW'(1);
					end else if (op_q == OP_ACCESS) begin
						if (!pres_q[fa]) begin
							pres_q[fa] <= 1'b1;
							evic_q[fa] <= 1'b0;
							if (k <= 4'd1) begin
								hot_q[fa] <= 1'b1;
								hlen_q    <= hlen_q + LW'(1);
							end else clen_q <= clen_q + LW'(1);
						end else if (push_q) begin
							hot_q[fa] <= 1'b1;
							hlen_q    <= (lst_q ? hlen_q : hlen_q) + LW'(1);
						end
					end else if (op_q == OP_MARK) begin
						if (pres_q[fa] && evic_q[fa] != flag_q) begin
							evic_q[fa] <= flag_q;
							if (flag_q) etot_q <= etot_q + LW'(1);
							else if (etot_q != '0) etot_q <= etot_q - LW'(1);
						end
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// assertions
	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(clen_q) + 32'(hlen_q)) <= FRAMES) else $error("list overflow");
	a_etot: assert property (@(posedge clk) disable iff (!arst_n)
		32'(etot_q) == $countones(evic_q)) else $error("evictable total drift");
	a_victim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && victim_valid |-> status == ST_OK) else $error("victim with error");
endmodule

### src/lkr_ram.sv
// ----------------------------------------------------------------------------
// lkr_ram: generic single-port-write, one-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module lkr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
